### hw/rtl/uars_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uars_pkg
// Shared types and constants of the upwind advection / relaxation step block.
// ----------------------------------------------------------------------------
package uars_pkg;

    localparam int GRID_POINTS_DEF = 64;
    localparam int WORD_W          = 32;
    localparam int PT_W            = 6;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int GSIZE_W         = 7;
    localparam int COEFF_W         = 16;
    localparam int DIFF_W          = WORD_W + 1;
    localparam int PROD_W          = DIFF_W + COEFF_W + 1;
    localparam int FRAC_SH         = 16;
    localparam int DELTA_W         = PROD_W - FRAC_SH;
    localparam int SUM_W           = DELTA_W + 1;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_STEP = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADVECT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAX     = 2'd2;

    localparam logic [GSIZE_W-1:0] GRID_SIZE_RST = 7'd64;
    localparam logic [COEFF_W-1:0] ADVECT_RST    = 16'd32768;
    localparam logic [COEFF_W-1:0] RELAX_RST     = 16'd0;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);
    localparam logic signed [SUM_W-1:0]  SAT_MAX    = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0]  SAT_MIN    = -SUM_W'(64'sd2147483648);

    typedef struct packed {
        logic [1:0]               action;
        logic [PT_W-1:0]          point_index;
        logic signed [WORD_W-1:0] u_in;
        logic signed [WORD_W-1:0] v_in;
    } t_in_item;

    typedef struct packed {
        logic [PT_W-1:0]          point_out;
        logic signed [WORD_W-1:0] u_out;
        logic signed [WORD_W-1:0] v_out;
        logic                     clipped;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_PRE,
        S_SWEEP,
        S_DRAIN,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

### hw/rtl/upwind_advection_relax_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upwind_advection_relax_step
// Periodic 1-D upwind advection of U with relaxation of V toward U, Q8.24.
//
// Input channel (i_in_valid / o_in_stall, payload t_in_item) carries load,
// step and read transactions; every transaction gives one result on the
// output channel (o_out_valid / i_out_stall, payload t_out_item).
// Load: written and answered in the accept cycle (result registered next).
// Read: answered from the registered read data of the grid memory.
// Step: one point per cycle through the single read port of the grid memory;
// the wrap-around neighbor is read in the accept cycle, then one read per point,
// followed by a multiply stage and a write-back stage before the result.
// One transaction at a time: loads every cycle while the output is not stalled.
// A finished result waits in the output register; a second one waits in a
// holding register, and the block then takes no transaction until the
// receiver drains the output. Configuration is written over i_cfg_*.
// Reset restores the register defaults and clears the saturation flag; grid
// contents are undefined until loaded.
// ----------------------------------------------------------------------------
module upwind_advection_relax_step #(
    parameter int GRID_POINTS = uars_pkg::GRID_POINTS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  uars_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output uars_pkg::t_out_item                 o_out_data,
    input  wire                                 i_cfg_we,
    input  wire [uars_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [uars_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    localparam int AW = $clog2(GRID_POINTS);
    localparam logic [31:0] GP = 32'(GRID_POINTS);
    localparam int W = uars_pkg::WORD_W;

    uars_pkg::t_state r_state, n_state;

    logic [uars_pkg::GSIZE_W-1:0] r_grid_size;
    logic [uars_pkg::COEFF_W-1:0] r_advect;
    logic [uars_pkg::COEFF_W-1:0] r_relax;

    logic [AW-1:0] r_cnt;
    logic [AW-1:0] r_last;
    logic signed [W-1:0] r_left;
    logic r_sat, n_sat;

    logic          r_p1, r_p1_last;
    logic [AW-1:0] r_p1_addr;
    logic          r_p2, r_p2_last;
    logic [AW-1:0] r_p2_addr;
    logic signed [uars_pkg::PROD_W-1:0] r_pu, r_pv;
    logic signed [W-1:0] r_uo, r_vo;

    logic [uars_pkg::PT_W-1:0] r_pt;
    logic                      r_rd_ok;

    uars_pkg::t_out_item r_res, r_out, res;
    logic r_out_valid;
    logic out_free, res_ready, in_acc, issue;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [2*W-1:0] mem_wdata, mem_rdata;
    logic signed [W-1:0] rd_u, rd_v;

    logic [31:0]   gs_w;
    logic [AW-1:0] last_calc;
    logic          idx_ok;

    logic signed [uars_pkg::DIFF_W-1:0]  diff_u, diff_v;
    logic signed [uars_pkg::PROD_W-1:0]  sum_u, sum_v;
    logic signed [uars_pkg::DELTA_W-1:0] du, dv;
    logic signed [uars_pkg::SUM_W-1:0]   nu_w, nv_w;
    logic signed [W-1:0] nu, nv;
    logic clip_u, clip_v;

    uars_grid_mem #(
        .DEPTH  (GRID_POINTS),
        .ADDR_W (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_u = mem_rdata[2*W-1:W];
    assign rd_v = mem_rdata[W-1:0];

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != uars_pkg::S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // last point index of the sweep, grid size clamped to 1..GRID_POINTS
    assign gs_w = 32'(r_grid_size);
    always_comb begin
        if (gs_w == 32'd0) begin
            last_calc = '0;
        end else if (gs_w > GP) begin
            last_calc = AW'(GP - 32'd1);
        end else begin
            last_calc = AW'(gs_w - 32'd1);
        end
    end

    assign idx_ok = (32'(i_in_data.point_index) < GP);

    // stage B: differences and products
    assign diff_u = {rd_u[W-1], rd_u} - {r_left[W-1], r_left};
    assign diff_v = {rd_v[W-1], rd_v} - {rd_u[W-1], rd_u};

    // stage C: round, subtract, saturate
    assign sum_u = r_pu + uars_pkg::ROUND_HALF;
    assign sum_v = r_pv + uars_pkg::ROUND_HALF;
    assign du    = sum_u[uars_pkg::PROD_W-1:uars_pkg::FRAC_SH];
    assign dv    = sum_v[uars_pkg::PROD_W-1:uars_pkg::FRAC_SH];
    assign nu_w  = uars_pkg::SUM_W'(r_uo) - uars_pkg::SUM_W'(du);
    assign nv_w  = uars_pkg::SUM_W'(r_vo) - uars_pkg::SUM_W'(dv);

    always_comb begin
        clip_u = 1'b0;
        clip_v = 1'b0;
        nu = nu_w[W-1:0];
        nv = nv_w[W-1:0];
        if (nu_w > uars_pkg::SAT_MAX) begin
            nu = uars_pkg::SAT_MAX[W-1:0];
            clip_u = 1'b1;
        end else if (nu_w < uars_pkg::SAT_MIN) begin
            nu = uars_pkg::SAT_MIN[W-1:0];
            clip_u = 1'b1;
        end
        if (nv_w > uars_pkg::SAT_MAX) begin
            nv = uars_pkg::SAT_MAX[W-1:0];
            clip_v = 1'b1;
        end else if (nv_w < uars_pkg::SAT_MIN) begin
            nv = uars_pkg::SAT_MIN[W-1:0];
            clip_v = 1'b1;
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = r_p2_addr;
        mem_wdata = {nu, nv};
        mem_raddr = r_cnt;
        issue     = 1'b0;
        res_ready = 1'b0;
        res       = '0;
        n_sat     = r_sat;
        if (r_p2) begin
            mem_we = 1'b1;
            n_sat  = r_sat | clip_u | clip_v;
        end
        case (r_state)
            uars_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_data.action)
                        uars_pkg::ACT_LOAD: begin
                            res_ready     = 1'b1;
                            res.point_out = i_in_data.point_index;
                            if (idx_ok) begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(i_in_data.point_index);
                                mem_wdata = {i_in_data.u_in, i_in_data.v_in};
                                res.u_out = i_in_data.u_in;
                                res.v_out = i_in_data.v_in;
                            end
                        end
                        uars_pkg::ACT_STEP: begin
                            mem_raddr = last_calc;
                            n_sat     = 1'b0;
                            n_state   = uars_pkg::S_PRE;
                        end
                        uars_pkg::ACT_READ: begin
                            mem_raddr = AW'(i_in_data.point_index);
                            n_state   = uars_pkg::S_READ;
                        end
                        default: begin
                            res_ready = 1'b1;
                        end
                    endcase
                end
            end
            uars_pkg::S_READ: begin
                res_ready     = 1'b1;
                res.point_out = r_pt;
                if (r_rd_ok) begin
                    res.u_out = rd_u;
                    res.v_out = rd_v;
                end
            end
            uars_pkg::S_PRE, uars_pkg::S_SWEEP: begin
                issue   = 1'b1;
                n_state = (r_cnt == r_last) ? uars_pkg::S_DRAIN : uars_pkg::S_SWEEP;
            end
            uars_pkg::S_DRAIN: begin
                if (r_p2 && r_p2_last) begin
                    res_ready = 1'b1;
                end
            end
            uars_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = uars_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = uars_pkg::S_IDLE;
            end
        endcase
        res.clipped = n_sat;
        if (res_ready) begin
            n_state = out_free ? uars_pkg::S_IDLE : uars_pkg::S_EMIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= uars_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= uars_pkg::GRID_SIZE_RST;
            r_advect    <= uars_pkg::ADVECT_RST;
            r_relax     <= uars_pkg::RELAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                uars_pkg::CFG_GRID_SIZE: r_grid_size <= i_cfg_wdata[uars_pkg::GSIZE_W-1:0];
                uars_pkg::CFG_ADVECT:    r_advect    <= i_cfg_wdata;
                uars_pkg::CFG_RELAX:     r_relax     <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // control state of the sweep and output side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_sat       <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sat <= n_sat;
            r_p1  <= issue;
            r_p2  <= r_p1;
            if ((r_state == uars_pkg::S_PRE) || r_p1) begin
                r_left <= rd_u;
            end
            if (res_ready && out_free) begin
                r_out_valid <= 1'b1;
            end else if ((r_state == uars_pkg::S_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pt    <= i_in_data.point_index;
            r_rd_ok <= idx_ok;
            r_cnt   <= '0;
            r_last  <= last_calc;
        end else if (issue) begin
            r_cnt <= r_cnt + AW'(1);
        end
        r_p1_last <= (r_cnt == r_last);
        r_p1_addr <= r_cnt;
        r_p2_last <= r_p1_last;
        r_p2_addr <= r_p1_addr;
        r_pu      <= $signed({1'b0, r_advect}) * diff_u;
        r_pv      <= $signed({1'b0, r_relax}) * diff_v;
        r_uo      <= rd_u;
        r_vo      <= rd_v;
        if (res_ready && out_free) begin
            r_out <= res;
        end else if ((r_state == uars_pkg::S_EMIT) && out_free) begin
            r_out <= r_res;
        end
        if (res_ready && !out_free) begin
            r_res <= res;
        end
    end

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1 || r_p2) |-> o_in_stall)
        else $error("sweep pipeline busy while input accepted");

    a_step_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_data.action == uars_pkg::ACT_STEP))
        |=> ((r_state == uars_pkg::S_PRE) && !r_sat))
        else $error("step did not start with a cleared flag");

    a_wb_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2 |-> ((r_state == uars_pkg::S_SWEEP) || (r_state == uars_pkg::S_DRAIN)))
        else $error("write-back outside a sweep");

endmodule
`default_nettype wire

### hw/rtl/uars_grid_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uars_grid_mem
// Grid store: one write port, one read port, registered read data (U in the
// upper half of each word, V in the lower half).
// ----------------------------------------------------------------------------
module uars_grid_mem #(
    parameter int DEPTH  = uars_pkg::GRID_POINTS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire                            i_clk,
    input  wire                            i_we,
    input  wire [ADDR_W-1:0]               i_waddr,
    input  wire [2*uars_pkg::WORD_W-1:0]   i_wdata,
    input  wire [ADDR_W-1:0]               i_raddr,
    output logic [2*uars_pkg::WORD_W-1:0]  o_rdata
);

    logic [2*uars_pkg::WORD_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for upwind_advection_relax_step. Load, step, read and
// unused-code transactions go through the input channel under random idling,
// a long output hold and register settings that reach the grid size and
// coefficient extremes. A local mirror of both grids and of the registers
// predicts every result, and the results are compared in order.
// ----------------------------------------------------------------------------
module testbench;
    import uars_pkg::*;

    localparam int NPTS           = GRID_POINTS_DEF;
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_ITEMS   = 1520;
    localparam logic signed [WORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] Q_MIN = 32'sh8000_0000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in_item              in_data;
    logic                  out_valid;
    logic                  out_stall;
    t_out_item             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // grid and register mirror
    logic signed [WORD_W-1:0] u_mirror [NPTS];
    logic signed [WORD_W-1:0] v_mirror [NPTS];
    logic [GSIZE_W-1:0]       size_reg;
    logic [COEFF_W-1:0]       advect_reg;
    logic [COEFF_W-1:0]       relax_reg;
    logic                     clip_flag;
    t_out_item                results_due [$];

    int idle_pct;
    int stall_pct;
    int hold_request;
    int hold_left;
    int idle_cycles;
    int n_errors;
    int n_results;
    int n_loads;
    int n_steps;
    int n_reads;
    int n_unused;
    int n_cfg_writes;

    upwind_advection_relax_step i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic signed [WORD_W-1:0] clamp_q824(longint x);
        if (x > longint'(Q_MAX)) begin
            clip_flag = 1'b1;
            return Q_MAX;
        end
        if (x < longint'(Q_MIN)) begin
            clip_flag = 1'b1;
            return Q_MIN;
        end
        return x[WORD_W-1:0];
    endfunction

    // round to nearest, ties up: floor((c * d + 2^15) / 2^16)
    function automatic longint scale_q16(logic [COEFF_W-1:0] coeff, longint diff);
        longint prod;
        prod = longint'(coeff) * diff + 64'sd32768;
        return prod >>> FRAC_SH;
    endfunction

    function automatic void advance_grid();
        int     n;
        longint left_u;
        longint u_old;
        longint v_old;
        n = int'(size_reg);
        if (n == 0) n = 1;
        if (n > NPTS) n = NPTS;
        clip_flag = 1'b0;
        left_u = u_mirror[n-1];
        for (int j = 0; j < n; j++) begin
            u_old = u_mirror[j];
            v_old = v_mirror[j];
            u_mirror[j] = clamp_q824(u_old - scale_q16(advect_reg, u_old - left_u));
            v_mirror[j] = clamp_q824(v_old - scale_q16(relax_reg, v_old - u_old));
            left_u = u_old;
        end
    endfunction

    function automatic t_out_item predict_result(t_in_item it);
        t_out_item r;
        r = '0;
        case (it.action)
            ACT_LOAD: begin
                u_mirror[it.point_index] = it.u_in;
                v_mirror[it.point_index] = it.v_in;
                r.point_out = it.point_index;
                r.u_out     = it.u_in;
                r.v_out     = it.v_in;
            end
            ACT_STEP: begin
                advance_grid();
            end
            ACT_READ: begin
                r.point_out = it.point_index;
                r.u_out     = u_mirror[it.point_index];
                r.v_out     = v_mirror[it.point_index];
            end
            default: ;
        endcase
        r.clipped = clip_flag;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic signed [WORD_W-1:0] rand_q824();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2, 3:    return {{8{raw[31]}}, raw[23:0]};
            default: return raw;
        endcase
    endfunction

    function automatic t_in_item mk_item(logic [1:0] act, int idx,
                                         logic signed [WORD_W-1:0] u,
                                         logic signed [WORD_W-1:0] v);
        t_in_item it;
        it.action      = act;
        it.point_index = PT_W'(idx);
        it.u_in        = u;
        it.v_in        = v;
        return it;
    endfunction

    function automatic t_in_item random_item();
        int         pick;
        logic [1:0] act;
        pick = $urandom_range(99);
        if (pick < 40)      act = ACT_LOAD;
        else if (pick < 75) act = ACT_READ;
        else if (pick < 93) act = ACT_STEP;
        else                act = ACT_NONE;
        return mk_item(act, $urandom_range(NPTS - 1), rand_q824(), rand_q824());
    endfunction

    function automatic logic [COEFF_W-1:0] rand_coeff();
        case ($urandom_range(6))
            0:       return '0;
            1:       return '1;
            default: return COEFF_W'($urandom);
        endcase
    endfunction

    task automatic send_item(t_in_item it);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        results_due.push_back(predict_result(it));
        case (it.action)
            ACT_LOAD: n_loads++;
            ACT_STEP: n_steps++;
            ACT_READ: n_reads++;
            default:  n_unused++;
        endcase
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_GRID_SIZE: size_reg   = val[GSIZE_W-1:0];
            CFG_ADVECT:    advect_reg = val;
            CFG_RELAX:     relax_reg  = val;
            default: ;
        endcase
        n_cfg_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(int gsize, logic [COEFF_W-1:0] ac, logic [COEFF_W-1:0] rc);
        wait_idle();
        write_reg(CFG_GRID_SIZE, CFG_DATA_W'(GSIZE_W'(gsize)));
        write_reg(CFG_ADVECT, ac);
        write_reg(CFG_RELAX, rc);
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    function automatic void note_mismatch(string what, t_out_item want, t_out_item got);
        n_errors++;
        if (n_errors <= 10)
            $display("%0t %s: exp pt=%0d u=%h v=%h clip=%b, got pt=%0d u=%h v=%h clip=%b",
                     $time, what, want.point_out, want.u_out, want.v_out, want.clipped,
                     got.point_out, got.u_out, got.v_out, got.clipped);
    endfunction

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            n_results++;
            if (results_due.size() == 0) begin
                note_mismatch("unexpected result", '0, out_data);
            end else begin
                want = results_due.pop_front();
                if (out_data.point_out !== want.point_out ||
                    out_data.u_out !== want.u_out ||
                    out_data.v_out !== want.v_out ||
                    out_data.clipped !== want.clipped) begin
                    note_mismatch("result mismatch", want, out_data);
                end
            end
        end
    end

    // receiver: random stalls, or a counted hold when one is requested
    always @(negedge clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("upwind_advection_relax_step: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_load_all_points();
        idle_pct  = 0;
        stall_pct = 0;
        for (int p = 0; p < NPTS; p++) begin
            if (p == 0)      send_item(mk_item(ACT_LOAD, p, Q_MAX, Q_MIN));
            else if (p == 1) send_item(mk_item(ACT_LOAD, p, Q_MIN, Q_MAX));
            else             send_item(mk_item(ACT_LOAD, p, rand_q824(), rand_q824()));
        end
    endtask

    task automatic test_directed_actions();
        send_item(mk_item(ACT_READ, 0, '0, '0));
        send_item(mk_item(ACT_READ, NPTS - 1, '1, '1));
        send_item(mk_item(ACT_NONE, NPTS - 1, Q_MAX, Q_MAX));
        send_item(mk_item(ACT_STEP, 0, '0, '0));
        send_item(mk_item(ACT_READ, 0, '0, '0));
        send_item(mk_item(ACT_READ, 1, '0, '0));
        send_item(mk_item(ACT_LOAD, NPTS - 1, Q_MIN, Q_MAX));
        send_item(mk_item(ACT_LOAD, 0, Q_MAX, Q_MIN));
        send_item(mk_item(ACT_STEP, NPTS - 1, Q_MIN, Q_MIN));
        send_item(mk_item(ACT_READ, 0, '0, '0));
        send_item(mk_item(ACT_READ, NPTS - 1, '0, '0));
        send_item(mk_item(ACT_NONE, 0, '0, '0));
    endtask

    // grid sizes below and above the legal range plus coefficient extremes
    task automatic test_register_corners();
        int               sizes [8]  = '{0, 1, 2, 3, NPTS, NPTS + 1, 127, 3};
        logic [COEFF_W-1:0] adv [8]  = '{0, 16'hFFFF, 16'h8000, 16'hFFFF, 0, 1, 16'hFFFF, 0};
        logic [COEFF_W-1:0] rel [8]  = '{0, 16'hFFFF, 1, 0, 16'hFFFF, 16'h8000, 16'hFFFF, 0};
        for (int k = 0; k < 8; k++) begin
            set_config(sizes[k], adv[k], rel[k]);
            send_item(mk_item(ACT_LOAD, 0, (k % 2) ? Q_MIN : Q_MAX, (k % 2) ? Q_MAX : Q_MIN));
            send_item(mk_item(ACT_STEP, 0, '0, '0));
            send_item(mk_item(ACT_READ, $urandom_range(2), '0, '0));
        end
    endtask

    task automatic test_random_traffic(int idle, int stall, int count);
        int chunk_left;
        idle_pct   = idle;
        stall_pct  = stall;
        chunk_left = 0;
        for (int k = 0; k < count; k++) begin
            if (chunk_left == 0) begin
                if ($urandom_range(9) == 0)
                    set_config($urandom_range(127), rand_coeff(), rand_coeff());
                else
                    set_config($urandom_range(3, NPTS), rand_coeff(), rand_coeff());
                chunk_left = $urandom_range(30, 90);
            end
            send_item(random_item());
            chunk_left--;
        end
    endtask

    // hold the output for a long stretch so the block fills and stalls its input
    task automatic test_output_hold();
        idle_pct  = 0;
        stall_pct = 0;
        wait_idle();
        hold_request = HOLD_CYCLES;
        for (int k = 0; k < 24; k++)
            send_item(mk_item((k % 6 == 5) ? ACT_STEP : ACT_READ,
                              $urandom_range(NPTS - 1), '0, '0));
        wait_idle();
    endtask

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_stall    = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = 0;
        hold_left    = 0;
        idle_cycles  = 0;
        n_errors     = 0;
        n_results    = 0;
        n_loads      = 0;
        n_steps      = 0;
        n_reads      = 0;
        n_unused     = 0;
        n_cfg_writes = 0;
        size_reg     = GRID_SIZE_RST;
        advect_reg   = ADVECT_RST;
        relax_reg    = RELAX_RST;
        clip_flag    = 1'b0;
        for (int p = 0; p < NPTS; p++) begin
            u_mirror[p] = '0;
            v_mirror[p] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_load_all_points();
        test_directed_actions();
        test_register_corners();
        test_random_traffic(0, 0, RANDOM_ITEMS / 4);
        test_random_traffic(62, 0, RANDOM_ITEMS / 4);
        test_random_traffic(0, 62, RANDOM_ITEMS / 4);
        test_random_traffic(32, 32, RANDOM_ITEMS / 4);
        test_output_hold();

        wait_idle();
        repeat (NPTS + 8) @(posedge clk);
        $display("covered %0d loads, %0d steps, %0d reads, %0d unused-code transactions, %0d results",
                 n_loads, n_steps, n_reads, n_unused, n_results);
        $display("over %0d register writes, four idling phases and one long output hold",
                 n_cfg_writes);
        if (n_errors == 0 && results_due.size() == 0) begin
            $display("upwind_advection_relax_step: match");
        end else begin
            $display("upwind_advection_relax_step: mismatch");
        end
        $finish;
    end

endmodule
